/* hdl/mats_pkg.sv */
// Shared types, character codes and helper functions for the MAC address text scanner.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package mats_pkg;

    localparam int TEXT_DEPTH    = 17;
    localparam int TEXT_IDX_W    = $clog2(TEXT_DEPTH);
    localparam int POS_W         = $clog2(TEXT_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int CHAR_W        = 8;
    localparam int NUM_W         = 16;
    localparam int OUT_TDATA_W   = CHAR_W + NUM_W;

    localparam logic [2:0]       GROUPS_NEEDED = 3'd6;
    localparam logic [2:0]       LAST_GROUP    = 3'd5;
    localparam logic [NUM_W-1:0] COUNT_MAX     = 16'hFFFF;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // One finished address waiting to be sent out
    typedef struct packed {
        logic [TEXT_DEPTH-1:0][CHAR_W-1:0] text;
        logic [POS_W-1:0]                  len;
        logic [NUM_W-1:0]                  number;
    } emit_entry_t;

    typedef struct packed {
        logic        valid;
        emit_entry_t entry;
    } push_t;

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
               (c >= CHAR_UA && c <= CHAR_UF);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

/* hdl/mats_front.sv */
// Front end: takes input items, runs the address recognizer, holds the candidate text.
// Hands each finished address to the queue as one entry. Depends on mats_pkg.
module mats_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mats_pkg::CHAR_W-1:0] s_tdata,   // [7:0] in_char
    input  logic                        s_tuser,   // [0] end_of_text
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        q_full,
    output mats_pkg::push_t             push
);

    logic [mats_pkg::TEXT_DEPTH-1:0][mats_pkg::CHAR_W-1:0] text_reg;
    logic [mats_pkg::POS_W-1:0] pos_reg, pos_next, e_pos;
    logic [1:0]                 dig_reg, dig_next, e_dig;
    logic [2:0]                 grp_reg, grp_next, e_grp;
    logic                       cmp_reg, cmp_next, e_cmp;
    logic [mats_pkg::NUM_W-1:0] found_reg, found_next, found_inc;
    logic                       dash_reg;
    logic                       pend, accept, text_we, sep;
    logic [mats_pkg::CHAR_W-1:0] c;

    assign cfg_ready = 1'b1;
    assign c         = s_tdata;
    // stall only when a finished address must go into a full queue
    assign pend      = (grp_reg == mats_pkg::GROUPS_NEEDED) && cmp_reg;
    assign s_tready  = !(pend && q_full);
    assign accept    = s_tvalid && s_tready;
    assign sep       = (c == mats_pkg::CHAR_COLON) || ((c == mats_pkg::CHAR_DASH) && dash_reg);
    assign found_inc = (found_reg != mats_pkg::COUNT_MAX) ? found_reg + 16'd1 : found_reg;

    always_comb begin
        // a pending address is sent and cleared before this item is scanned
        e_pos = pend ? '0 : pos_reg;
        e_dig = pend ? '0 : dig_reg;
        e_grp = pend ? '0 : grp_reg;
        e_cmp = pend ? 1'b0 : cmp_reg;

        pos_next   = pos_reg;
        dig_next   = dig_reg;
        grp_next   = grp_reg;
        cmp_next   = cmp_reg;
        found_next = found_reg;
        text_we    = 1'b0;

        push.valid        = accept && pend;
        push.entry.text   = text_reg;
        push.entry.len    = pos_reg;
        push.entry.number = found_inc;

        if (accept) begin
            pos_next = e_pos;
            dig_next = e_dig;
            grp_next = e_grp;
            cmp_next = e_cmp;
            if (pend) begin
                found_next = found_inc;
            end
            if (s_tuser) begin
                pos_next   = '0;
                dig_next   = '0;
                grp_next   = '0;
                cmp_next   = 1'b0;
                found_next = '0;
            end else if (!mats_pkg::is_blank(c)) begin
                if (mats_pkg::is_hex(c) && e_dig < 2'd2 && e_grp < mats_pkg::GROUPS_NEEDED) begin
                    if (e_pos >= mats_pkg::POS_W'(mats_pkg::TEXT_DEPTH)) begin
                        pos_next = '0;
                        dig_next = '0;
                        grp_next = '0;
                        cmp_next = 1'b0;
                    end else begin
                        text_we  = 1'b1;
                        pos_next = e_pos + mats_pkg::POS_W'(1);
                        dig_next = e_dig + 2'd1;
                        if (e_grp == mats_pkg::LAST_GROUP && e_dig == 2'd1) begin
                            grp_next = mats_pkg::GROUPS_NEEDED;
                            cmp_next = 1'b1;
                        end
                    end
                end else if (sep && e_dig != 2'd0) begin
                    if (e_pos >= mats_pkg::POS_W'(mats_pkg::TEXT_DEPTH)) begin
                        pos_next = '0;
                        dig_next = '0;
                        grp_next = '0;
                        cmp_next = 1'b0;
                    end else begin
                        text_we  = 1'b1;
                        pos_next = e_pos + mats_pkg::POS_W'(1);
                        dig_next = '0;
                        grp_next = e_grp + 3'd1;
                    end
                end else begin
                    pos_next = '0;
                    dig_next = '0;
                    grp_next = '0;
                    cmp_next = 1'b0;
                end
            end else if (e_grp == mats_pkg::LAST_GROUP && e_dig != 2'd0) begin
                // whitespace ends a one-digit last group
                grp_next = mats_pkg::GROUPS_NEEDED;
                cmp_next = 1'b1;
            end else begin
                pos_next = '0;
                dig_next = '0;
                grp_next = '0;
                cmp_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            dig_reg   <= '0;
            grp_reg   <= '0;
            cmp_reg   <= 1'b0;
            found_reg <= '0;
            dash_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            dig_reg   <= dig_next;
            grp_reg   <= grp_next;
            cmp_reg   <= cmp_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready) begin
                dash_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (text_we) begin
            text_reg[e_pos[mats_pkg::TEXT_IDX_W-1:0]] <= c;
        end
    end

endmodule

/* hdl/mats_queue.sv */
// Small FIFO of finished addresses between the scanner front end and the output stage.
// Depends on mats_pkg for the entry type.
module mats_queue #(
    parameter int DEPTH = mats_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mats_pkg::push_t       push,
    input  logic                  pop,
    output logic                  q_valid,
    output logic                  q_full,
    output mats_pkg::emit_entry_t q_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mats_pkg::emit_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign q_valid = (cnt_reg != '0);
    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_entry = slot_reg[rd_ptr_reg];
    assign do_push = push.valid && !q_full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

/* hdl/mats_back.sv */
// Output stage: walks the head queue entry one character per cycle into the output register
// while the output register is empty or m_tready is high. Depends on mats_pkg.
module mats_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  mats_pkg::emit_entry_t            q_entry,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mats_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] out_char, [23:8] address_number
    output logic                             m_tlast   // out_last
);

    logic [mats_pkg::TEXT_IDX_W-1:0]  idx_reg;
    logic                             valid_reg;
    logic [mats_pkg::OUT_TDATA_W-1:0] data_reg;
    logic                             last_reg;
    logic                             load, is_last;

    assign load    = q_valid && (!valid_reg || m_tready);
    assign is_last = (mats_pkg::POS_W'(idx_reg) + mats_pkg::POS_W'(1)) == q_entry.len;
    assign pop     = load && is_last;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : idx_reg + mats_pkg::TEXT_IDX_W'(1);
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {q_entry.number, q_entry.text[idx_reg]};
            last_reg <= is_last;
        end
    end

endmodule

/* hdl/mac_address_text_scanner_core.sv */
// Usage:
//   Input stream s_*: one text byte per item in s_tdata[7:0]; s_tuser high marks
//   end of text (byte ignored, a finished address is flushed, scanner and count reset).
//   Output stream m_*: one character of a found address per item, m_tdata[7:0] the
//   character, m_tdata[23:8] the address number within the text, m_tlast on its last
//   character. cfg_valid/cfg_data write accept_dash (dash as group separator).
//   Throughput: one input item per cycle. An address is released by the item after it
//   ends; that item pushes it into a two-entry queue. The output stage sends one
//   character per cycle (11 to 17 per address), so the queue port toward the front
//   sets the input rate: s_tready drops only when an address must be queued while both
//   queue slots still hold addresses, i.e. when the receiver stalls m_tready.
//   Path to the first character: a queue slot, then the output register.
//   Reset (aresetn low, synchronous) clears the scanner, the count, the queue, the
//   output valid flag and accept_dash. Candidate text storage is not cleared and needs
//   no clearing pass. A stalled receiver holds the current character; scanning goes on
//   until the queue fills.
// Top level; instantiates mats_front, mats_queue and mats_back, depends on mats_pkg.
module mac_address_text_scanner_core #(
    parameter int QUEUE_DEPTH = mats_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mats_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] in_char
    input  logic                             s_tuser,   // [0] end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mats_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_char, [23:8] address_number
    output logic                             m_tlast,   // out_last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data   // accept_dash
);

    mats_pkg::push_t       push;
    mats_pkg::emit_entry_t q_entry;
    logic                  q_valid, q_full, pop;

    mats_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push)
    );

    mats_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_full  (q_full),
        .q_entry (q_entry)
    );

    mats_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a finished address is never offered to a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && q_full))
        else $error("address pushed into full queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // characters of one address follow without gaps
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside an address");

endmodule
